// ===== sv/bech32_checksum_engine_defines.svh =====
// Assertion macros for the Bech32 checksum engine
`ifndef BECH32_CHECKSUM_ENGINE_DEFINES_SVH
`define BECH32_CHECKSUM_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BCE_ASSERT(lbl, prop, msg)
`define BCE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== sv/bce_pkg.sv =====
// Types, constants and the residue step shared by the Bech32 checksum engine
package bce_pkg;

  localparam int HRP_DEPTH = 128;
  localparam int LEN_W     = $clog2(HRP_DEPTH + 1);
  localparam int ADDR_W    = (HRP_DEPTH > 1) ? $clog2(HRP_DEPTH) : 1;
  localparam int CNT_W     = (LEN_W > 3) ? LEN_W : 3;

  localparam logic [29:0] RES_ONE       = 30'h0000_0001;
  localparam logic [29:0] CONST_BECH32  = 30'h0000_0001;
  localparam logic [29:0] CONST_BECH32M = 30'h2bc8_30a3;

  localparam logic [29:0] GEN_MULT [5] = '{
    30'h3b6a_57b2, 30'h2650_8e6d, 30'h1ea1_19fa, 30'h3d42_33dd, 30'h2a14_62b3
  };

  // Input codes
  localparam logic OP_HRP  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CREATE_MODE = 1'b0;
  localparam logic CFG_VARIANT     = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_BECH32   = 2'd1;
  localparam logic [1:0] ST_BECH32M  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic       op;
    logic [6:0] hrp_char;
    logic [4:0] symbol;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] check_symbol;
    logic       end_of_run;
  } out_word_t;

  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [4:0] sym;
  } pm_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH0,
    S_FLUSH,
    S_ZERO,
    S_EMIT
  } state_t;

  function automatic logic [29:0] polymod_step(input logic [29:0] res, input logic [4:0] sym);
    logic [29:0] r;
    r = {res[24:0], 5'b0} ^ {25'b0, sym};
    for (int i = 0; i < 5; i++) begin
      if (res[25 + i]) begin
        r = r ^ GEN_MULT[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/bce_polymod.sv =====
// Residue register of the BCH polymod with its one-symbol update
module bce_polymod import bce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pm_cmd_t     cmd,
  output logic [29:0] residue
);

  logic [29:0] residue_r;
  logic [29:0] residue_nxt;

  always_comb begin
    residue_nxt = residue_r;
    if (cmd.clear) begin
      residue_nxt = RES_ONE;
    end else if (cmd.feed) begin
      residue_nxt = polymod_step(residue_r, cmd.sym);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_r <= RES_ONE;
    end else begin
      residue_r <= residue_nxt;
    end
  end

  assign residue = residue_r;

endmodule

// ===== sv/bech32_checksum_engine.sv =====
// Bech32 / Bech32m checksum engine: top level with sequencer and HRP low-part buffer
//
// Takes one string at a time as a run of words, HRP characters first, then
// data symbols, the final word marked by last. An HRP character, or a data
// symbol after the flush, is taken in the idle state. The first data symbol,
// or the last word if no data came, triggers the flush of the buffered HRP
// low parts: a separator zero, then each low part through the one read port
// of the buffer memory, then any pending data symbol; the residue unit takes
// one symbol per cycle. A verify finish, or one after overflow, gives one
// result word; a create finish feeds six zero symbols, then gives six result
// words at one per cycle while the output is taken. No new word is taken
// until a string's last result is in the output register. The buffer holds
// 128 characters; beyond that the string ends with status overflow.
`include "bech32_checksum_engine_defines.svh"
module bech32_checksum_engine import bce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_wdata
);

  state_t st_r, st_nxt;

  logic             create_r, variant_r;
  logic [LEN_W-1:0] len_r;
  logic             flushed_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_data_r, pend_last_r;
  logic [4:0]       pend_sym_r;
  logic [4:0]       rdata_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic [4:0]       hrp_mem [HRP_DEPTH];

  pm_cmd_t          pm_cmd;
  logic [29:0]      residue;

  logic             acc, slot_free, create_run, emit_last, flush_more;
  logic             mem_we, ovf_set, flushed_set, cnt_inc, emit_fire, str_clear;
  logic [ADDR_W-1:0] rd_addr;
  state_t           fin_state;
  out_word_t        emit_word;
  logic [29:0]      mod_word;
  logic [2:0]       grp;

  assign acc        = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign create_run = create_r && !ovf_r;
  assign emit_last  = !create_run || (cnt_r == CNT_W'(5));
  assign flush_more = cnt_r < CNT_W'(len_r);
  assign fin_state  = create_run ? S_ZERO : S_EMIT;

  bce_polymod u_polymod (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (pm_cmd),
    .residue (residue)
  );

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (flushed_r) begin
            st_nxt = in_data.last ? fin_state : S_IDLE;
          end else if (in_data.op == OP_DATA || in_data.last) begin
            st_nxt = S_FLUSH0;
          end
        end
      end
      S_FLUSH0: st_nxt = S_FLUSH;
      S_FLUSH: begin
        if (!flush_more) begin
          st_nxt = pend_last_r ? fin_state : S_IDLE;
        end
      end
      S_ZERO: begin
        if (cnt_r == CNT_W'(5)) begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free && emit_last) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    in_ready    = 1'b0;
    pm_cmd      = '0;
    mem_we      = 1'b0;
    ovf_set     = 1'b0;
    flushed_set = 1'b0;
    cnt_inc     = 1'b0;
    emit_fire   = 1'b0;
    str_clear   = 1'b0;
    rd_addr     = '0;
    unique case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (acc && in_data.op == OP_HRP && !flushed_r) begin
          if (len_r >= LEN_W'(HRP_DEPTH)) begin
            ovf_set = 1'b1;
          end else begin
            pm_cmd.feed = 1'b1;
            pm_cmd.sym  = {3'b000, in_data.hrp_char[6:5]};
            mem_we      = 1'b1;
          end
        end else if (acc && in_data.op == OP_DATA && flushed_r) begin
          pm_cmd.feed = 1'b1;
          pm_cmd.sym  = in_data.symbol;
        end
      end
      S_FLUSH0: begin
        // separator zero, and start reading the first buffered low part
        pm_cmd.feed = 1'b1;
        rd_addr     = '0;
      end
      S_FLUSH: begin
        if (flush_more) begin
          pm_cmd.feed = 1'b1;
          pm_cmd.sym  = rdata_r;
          cnt_inc     = 1'b1;
          rd_addr     = ADDR_W'(cnt_r + CNT_W'(1));
        end else begin
          flushed_set = 1'b1;
          pm_cmd.feed = pend_data_r;
          pm_cmd.sym  = pend_sym_r;
        end
      end
      S_ZERO: begin
        pm_cmd.feed = 1'b1;
        cnt_inc     = 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit_fire    = 1'b1;
          cnt_inc      = 1'b1;
          str_clear    = emit_last;
          pm_cmd.clear = emit_last;
        end
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    mod_word  = residue ^ (variant_r ? CONST_BECH32M : CONST_BECH32);
    grp       = 3'd5 - cnt_r[2:0];
    emit_word = '0;
    emit_word.end_of_run = emit_last;
    if (ovf_r) begin
      emit_word.status = ST_OVERFLOW;
    end else if (create_r) begin
      emit_word.status       = variant_r ? ST_BECH32M : ST_BECH32;
      emit_word.check_symbol = mod_word[grp*5 +: 5];
    end else if (residue == CONST_BECH32) begin
      emit_word.status = ST_BECH32;
    end else if (residue == CONST_BECH32M) begin
      emit_word.status = ST_BECH32M;
    end else begin
      emit_word.status = ST_INVALID;
    end
  end

  // HRP low-part buffer; writes come only in the idle state, read data is used only while flushing
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hrp_mem[len_r[ADDR_W-1:0]] <= in_data.hrp_char[4:0];
    end
    rdata_r <= hrp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      create_r    <= 1'b0;
      variant_r   <= 1'b0;
      len_r       <= '0;
      flushed_r   <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      pend_data_r <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == CFG_CREATE_MODE) begin
        create_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_VARIANT) begin
        variant_r <= cfg_wdata;
      end
      if (str_clear) begin
        len_r     <= '0;
        flushed_r <= 1'b0;
        ovf_r     <= 1'b0;
      end else begin
        if (mem_we) begin
          len_r <= len_r + LEN_W'(1);
        end
        if (flushed_set) begin
          flushed_r <= 1'b1;
        end
        if (ovf_set) begin
          ovf_r <= 1'b1;
        end
      end
      if (st_nxt != st_r) begin
        cnt_r <= '0;
      end else if (cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (acc) begin
        pend_data_r <= (in_data.op == OP_DATA);
        pend_last_r <= in_data.last;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_sym_r <= in_data.symbol;
    end
    if (emit_fire) begin
      out_r <= emit_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BCE_ASSERT(a_flush_bound, (st_r == S_FLUSH) |-> (cnt_r <= CNT_W'(len_r)), "flush ran past buffer fill")
  `BCE_ASSERT(a_ovf_full, ovf_r |-> (len_r == LEN_W'(HRP_DEPTH)), "overflow with buffer not full")
  `BCE_ASSERT(a_len_bound, len_r <= LEN_W'(HRP_DEPTH), "buffer fill beyond depth")
  `BCE_ASSERT_NEXT(a_run_end, emit_fire && emit_last, st_r == S_IDLE && len_r == '0 && !flushed_r, "string state not cleared after final result")

endmodule
